// ----- rtl/mmp_pkg.sv -----
// ----------------------------------------------------------------------------
// mmp_pkg
// shared types, constants and the status length decode for the midi parser
// ----------------------------------------------------------------------------
package mmp_pkg;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    // message length codes
    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // fill index codes
    localparam logic [1:0] FILL_EMPTY  = 2'd0;
    localparam logic [1:0] FILL_STATUS = 2'd1;
    localparam logic [1:0] FILL_FIRST  = 2'd2;

    typedef enum logic [1:0] {
        PS_WAIT   = 2'd0,
        PS_READ   = 2'd1,
        PS_IGNORE = 2'd2
    } parse_state_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic [1:0] message_length;
    } msg_t;

    // total message length for a status byte, none for data or unknown bytes
    function automatic logic [1:0] msg_length(input logic [7:0] s);
        logic [1:0] len;
        len = LEN_NONE;
        if (s[7:4] != 4'hF) begin
            case (s[7:4]) inside
                4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = LEN_THREE;
                4'hC, 4'hD:                   len = LEN_TWO;
                default:                      len = LEN_NONE;
            endcase
        end
        else begin
            case (s) inside
                8'hF1, 8'hF3:                 len = LEN_TWO;
                8'hF2:                        len = LEN_THREE;
                8'hF6, 8'hF8, 8'hF9, 8'hFA,
                8'hFB, 8'hFC, 8'hFE, 8'hFF:   len = LEN_ONE;
                default:                      len = LEN_NONE;
            endcase
        end
        return len;
    endfunction

endpackage

// ----- rtl/mmp_byte_if.sv -----
// ----------------------------------------------------------------------------
// mmp_byte_if
// valid/ready channel carrying one received midi byte
// ----------------------------------------------------------------------------
interface mmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/mmp_msg_if.sv -----
// ----------------------------------------------------------------------------
// mmp_msg_if
// valid/ready channel carrying one assembled midi message
// ----------------------------------------------------------------------------
interface mmp_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic [1:0] message_length;

    modport source (output valid, output status_byte, output first_data,
                    output second_data, output message_length, input ready);
    modport sink   (input valid, input status_byte, input first_data,
                    input second_data, input message_length, output ready);
endinterface

// ----- rtl/mmp_core.sv -----
// ----------------------------------------------------------------------------
// mmp_core
// input byte register, parse state machine and message assembly
// ----------------------------------------------------------------------------
module mmp_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [7:0]    in_byte,
    output logic          in_ready,
    output logic          res_valid,
    output mmp_pkg::msg_t res,
    input  logic          res_ready
);

    logic                  byte_valid_reg;
    logic [7:0]            byte_reg;
    mmp_pkg::parse_state_t state_reg;
    mmp_pkg::parse_state_t state_next;
    logic [1:0]            fill_reg;
    logic [1:0]            fill_next;
    logic [7:0]            status_reg;
    logic [7:0]            status_next;
    logic [7:0]            data1_reg;
    logic [7:0]            data1_next;
    logic [1:0]            cur_len;
    logic [1:0]            byte_len;
    logic                  advance;

    assign cur_len  = mmp_pkg::msg_length(status_reg);
    assign byte_len = mmp_pkg::msg_length(byte_reg);
    assign advance  = byte_valid_reg && (!res_valid || res_ready);
    assign in_ready = !byte_valid_reg || advance;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmp_pkg::PS_READ:
            begin
                if (fill_reg != mmp_pkg::FILL_STATUS || cur_len == mmp_pkg::LEN_TWO) begin
                    state_next = mmp_pkg::PS_WAIT;
                end
            end
            mmp_pkg::PS_IGNORE:
            begin
                if (byte_reg == mmp_pkg::SYSEX_END) begin
                    state_next = mmp_pkg::PS_WAIT;
                end
            end
            default:
            begin
                if (byte_reg == mmp_pkg::SYSEX_START) begin
                    state_next = mmp_pkg::PS_IGNORE;
                end
                else if (byte_len == mmp_pkg::LEN_TWO || byte_len == mmp_pkg::LEN_THREE) begin
                    state_next = mmp_pkg::PS_READ;
                end
                else begin
                    state_next = mmp_pkg::PS_WAIT;
                end
            end
        endcase
    end

    // outputs and buffer updates
    always_comb
    begin
        res_valid   = 1'b0;
        res         = '0;
        fill_next   = fill_reg;
        status_next = status_reg;
        data1_next  = data1_reg;
        case (state_reg)
            mmp_pkg::PS_READ:
            begin
                if (fill_reg == mmp_pkg::FILL_STATUS && cur_len == mmp_pkg::LEN_TWO) begin
                    res_valid          = byte_valid_reg;
                    res.status_byte    = status_reg;
                    res.first_data     = byte_reg;
                    res.message_length = mmp_pkg::LEN_TWO;
                    fill_next          = mmp_pkg::FILL_EMPTY;
                end
                else if (fill_reg == mmp_pkg::FILL_STATUS) begin
                    data1_next = byte_reg;
                    fill_next  = mmp_pkg::FILL_FIRST;
                end
                else begin
                    res_valid          = byte_valid_reg;
                    res.status_byte    = status_reg;
                    res.first_data     = data1_reg;
                    res.second_data    = byte_reg;
                    res.message_length = mmp_pkg::LEN_THREE;
                    fill_next          = mmp_pkg::FILL_EMPTY;
                end
            end
            mmp_pkg::PS_IGNORE:
            begin
                fill_next = fill_reg;
            end
            default:
            begin
                if (byte_reg != mmp_pkg::SYSEX_START) begin
                    if (byte_len == mmp_pkg::LEN_ONE) begin
                        res_valid          = byte_valid_reg;
                        res.status_byte    = byte_reg;
                        res.message_length = mmp_pkg::LEN_ONE;
                    end
                    else if (byte_len != mmp_pkg::LEN_NONE) begin
                        status_next = byte_reg;
                        fill_next   = mmp_pkg::FILL_STATUS;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_valid_reg <= 1'b0;
            state_reg      <= mmp_pkg::PS_WAIT;
            fill_reg       <= mmp_pkg::FILL_EMPTY;
        end
        else begin
            if (in_ready) begin
                byte_valid_reg <= in_valid;
            end
            if (advance) begin
                state_reg <= state_next;
                fill_reg  <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            byte_reg <= in_byte;
        end
        if (advance) begin
            status_reg <= status_next;
            data1_reg  <= data1_next;
        end
    end

    // every emitted message leaves the parser waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid |=> state_reg == mmp_pkg::PS_WAIT)
        else $error("parser not waiting after message");

    // collecting always has the status byte stored
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mmp_pkg::PS_READ |-> fill_reg != mmp_pkg::FILL_EMPTY)
        else $error("collecting with empty buffer");

    // stored status of a collected message is a multi-byte one
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mmp_pkg::PS_READ |->
            (cur_len == mmp_pkg::LEN_TWO || cur_len == mmp_pkg::LEN_THREE))
        else $error("collecting message of bad length");

endmodule

// ----- rtl/mmp_out_reg.sv -----
// ----------------------------------------------------------------------------
// mmp_out_reg
// result register holding one assembled message until it is taken
// ----------------------------------------------------------------------------
module mmp_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    input  mmp_pkg::msg_t res,
    output logic          res_ready,
    output logic          out_valid,
    output mmp_pkg::msg_t out_msg,
    input  logic          out_ready
);

    logic          valid_reg;
    mmp_pkg::msg_t msg_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_msg   = msg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid) begin
            msg_reg <= res;
        end
    end

    // a held message always carries a real length
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> msg_reg.message_length != mmp_pkg::LEN_NONE)
        else $error("message with zero length");

endmodule

// ----- rtl/midi_message_parser.sv -----
// ----------------------------------------------------------------------------
// midi_message_parser
// assembles complete midi messages from a stream of received bytes
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                          | request
//  --------+-----+--------------------------------------------------+--------------
//  rx      | in  | rx_byte[7:0]                                     | one byte
//  msg     | out | status_byte, first_data, second_data, length     | one message
//
//  one byte per cycle unless a completing byte waits for space; a byte passes
//  an input register and combinational decode, and the message is driven
//  onto msg from the result register
//  rst_n clears the parse state and both valid flags asynchronously
//  a stall on msg holds the result register; bytes that yield no message keep
//  flowing while it is full, a byte that completes a message waits for space
//
module midi_message_parser (
    input  logic         clk,
    input  logic         rst_n,
    mmp_byte_if.sink     rx,
    mmp_msg_if.source    msg
);

    // core to result register
    logic          res_valid;
    logic          res_ready;
    mmp_pkg::msg_t res;
    mmp_pkg::msg_t out_msg;

    // byte register, state machine and buffer
    mmp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_byte   (rx.rx_byte),
        .in_ready  (rx.ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // result register toward the message consumer
    mmp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (msg.valid),
        .out_msg   (out_msg),
        .out_ready (msg.ready)
    );

    // unpack the held message onto the channel
    assign msg.status_byte    = out_msg.status_byte;
    assign msg.first_data     = out_msg.first_data;
    assign msg.second_data    = out_msg.second_data;
    assign msg.message_length = out_msg.message_length;

endmodule
